// ===== rtl/vlan_ipv4_udp_frame_generator_assert.svh =====
// assertion macros for the frame generator
// expects signals named clock and reset in the including scope
`ifndef VLAN_IPV4_UDP_FRAME_GENERATOR_ASSERT_SVH
`define VLAN_IPV4_UDP_FRAME_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define VUG_CHECK_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vug check failed");
`define VUG_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vug check failed");
`else
`define VUG_CHECK_NOW(lbl, ante, cons)
`define VUG_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/vug_pkg.sv =====
// shared types and constants for the vlan/ipv4/udp frame generator
// no dependencies
`timescale 1ns / 1ps
package vug_pkg;

   // register map
   typedef enum logic [2:0] {
      REG_VIRTUAL_LINK_ID   = 3'd0,
      REG_VLAN_TAGGED       = 3'd1,
      REG_VLAN_NUMBER       = 3'd2,
      REG_VLAN_PRIORITY     = 3'd3,
      REG_TAIL_STAMP_MODE   = 3'd4,
      REG_HEAD_STAMP_ENABLE = 3'd5,
      REG_MESSAGE_LENGTH    = 3'd6
   } csr_index_type;

   // tail stamp codes, the fourth code acts as none
   localparam logic [1:0] TAIL_NONE = 2'd0;
   localparam logic [1:0] TAIL_BYTE = 2'd1;
   localparam logic [1:0] TAIL_WORD = 2'd2;

   // register reset values
   localparam logic [15:0] RST_VIRTUAL_LINK_ID   = 16'd15;
   localparam logic        RST_VLAN_TAGGED       = 1'b1;
   localparam logic [11:0] RST_VLAN_NUMBER       = 12'd97;
   localparam logic [2:0]  RST_VLAN_PRIORITY     = 3'd0;
   localparam logic [1:0]  RST_TAIL_STAMP_MODE   = TAIL_BYTE;
   localparam logic        RST_HEAD_STAMP_ENABLE = 1'b0;
   localparam logic [15:0] RST_MESSAGE_LENGTH    = 16'd11;

   // frame geometry in bytes
   localparam int BEAT_BYTES      = 8;
   localparam int ETH_HDR_BYTES   = 14;
   localparam int VLAN_TAG_BYTES  = 4;
   localparam int IP_HDR_BYTES    = 20;
   localparam int UDP_HDR_BYTES   = 8;
   localparam int REQ_HDR_BYTES   = 11;
   localparam int STAMP_BYTES     = 8;
   localparam int MIN_FRAME_BYTES = 60;

   // fixed header bytes
   localparam logic [7:0] DST_MAC_FIRST = 8'h03;
   localparam logic [7:0] SRC_MAC_FIRST = 8'h02;
   localparam logic [7:0] SRC_MAC_LAST  = 8'h20;
   localparam logic [7:0] TPID_HI       = 8'h81;
   localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
   localparam logic [7:0] IP_VER_IHL    = 8'h45;
   localparam logic [7:0] IP_TTL        = 8'h01;
   localparam logic [7:0] IP_PROTO_UDP  = 8'h11;
   localparam logic [7:0] IP_SRC_NET    = 8'h0A;
   localparam logic [7:0] IP_MCAST      = 8'hE0;
   localparam logic [7:0] UDP_PORT      = 8'd100;
   localparam logic [7:0] REQ_ID        = 8'h32;

   // everything the back end needs to stream one frame
   typedef struct packed {
      logic [15:0] vlid;
      logic        vlan_on;
      logic [15:0] tci;
      logic [1:0]  tail;
      logic        head;
      logic [15:0] msg_len;
      logic [4:0]  payload_len;
      logic [15:0] ip_csum;
      logic [6:0]  frame_len;
      logic [3:0]  word_count;
      logic [63:0] ts;
      logic [63:0] seq;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/vug_front.sv =====
// front end: config registers, sequence counter, frame descriptor build
// depends on vug_pkg
`timescale 1ns / 1ps
module vug_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [63:0]         req_timestamp_ns,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  vug_pkg::q_stat_type q_stat,
   output logic                push,
   output vug_pkg::desc_type   push_desc
);

   logic [15:0] vlid_ff, vlid_in;
   logic        vlan_on_ff, vlan_on_in;
   logic [11:0] vlan_num_ff, vlan_num_in;
   logic [2:0]  vlan_prio_ff, vlan_prio_in;
   logic [1:0]  tail_ff, tail_in;
   logic        head_ff, head_in;
   logic [15:0] msg_len_ff, msg_len_in;
   logic [63:0] seq_ff, seq_in;

   logic [4:0]  payload_len;
   logic [6:0]  body_len;
   logic [6:0]  frame_len;
   logic [6:0]  len_round;
   logic [15:0] ip_len;
   logic [17:0] csum_sum;
   logic [16:0] csum_fold;
   logic [15:0] csum_final;

   assign csr_ready = 1'b1;
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      vlid_in      = vlid_ff;
      vlan_on_in   = vlan_on_ff;
      vlan_num_in  = vlan_num_ff;
      vlan_prio_in = vlan_prio_ff;
      tail_in      = tail_ff;
      head_in      = head_ff;
      msg_len_in   = msg_len_ff;
      if (csr_valid) begin
         unique case (vug_pkg::csr_index_type'(csr_index))
            vug_pkg::REG_VIRTUAL_LINK_ID:   vlid_in      = csr_data;
            vug_pkg::REG_VLAN_TAGGED:       vlan_on_in   = csr_data[0];
            vug_pkg::REG_VLAN_NUMBER:       vlan_num_in  = csr_data[11:0];
            vug_pkg::REG_VLAN_PRIORITY:     vlan_prio_in = csr_data[2:0];
            vug_pkg::REG_TAIL_STAMP_MODE:   tail_in      = csr_data[1:0];
            vug_pkg::REG_HEAD_STAMP_ENABLE: head_in      = csr_data[0];
            vug_pkg::REG_MESSAGE_LENGTH:    msg_len_in   = csr_data;
            default: ;
         endcase
      end
      seq_in = push ? seq_ff + 64'd1 : seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlid_ff      <= vug_pkg::RST_VIRTUAL_LINK_ID;
         vlan_on_ff   <= vug_pkg::RST_VLAN_TAGGED;
         vlan_num_ff  <= vug_pkg::RST_VLAN_NUMBER;
         vlan_prio_ff <= vug_pkg::RST_VLAN_PRIORITY;
         tail_ff      <= vug_pkg::RST_TAIL_STAMP_MODE;
         head_ff      <= vug_pkg::RST_HEAD_STAMP_ENABLE;
         msg_len_ff   <= vug_pkg::RST_MESSAGE_LENGTH;
         seq_ff       <= '0;
      end else begin
         vlid_ff      <= vlid_in;
         vlan_on_ff   <= vlan_on_in;
         vlan_num_ff  <= vlan_num_in;
         vlan_prio_ff <= vlan_prio_in;
         tail_ff      <= tail_in;
         head_ff      <= head_in;
         msg_len_ff   <= msg_len_in;
         seq_ff       <= seq_in;
      end
   end

   // payload and frame length
   always_comb begin
      payload_len = 5'(vug_pkg::REQ_HDR_BYTES)
                  + (head_ff ? 5'(vug_pkg::STAMP_BYTES) : 5'd0);
      if (tail_ff == vug_pkg::TAIL_BYTE) begin
         payload_len = payload_len + 5'd1;
      end else if (tail_ff == vug_pkg::TAIL_WORD) begin
         payload_len = payload_len + 5'(vug_pkg::STAMP_BYTES);
      end
      body_len = 7'(vug_pkg::ETH_HDR_BYTES + vug_pkg::IP_HDR_BYTES + vug_pkg::UDP_HDR_BYTES)
               + (vlan_on_ff ? 7'(vug_pkg::VLAN_TAG_BYTES) : 7'd0)
               + 7'(payload_len);
      frame_len = (body_len < 7'(vug_pkg::MIN_FRAME_BYTES))
                ? 7'(vug_pkg::MIN_FRAME_BYTES) : body_len;
      len_round = frame_len + 7'(vug_pkg::BEAT_BYTES - 1);
      ip_len    = 16'(vug_pkg::IP_HDR_BYTES + vug_pkg::UDP_HDR_BYTES) + 16'(payload_len);
   end

   // ipv4 header checksum, only length and link id vary
   always_comb begin
      csum_sum = 18'({vug_pkg::IP_VER_IHL, 8'h00})
               + 18'(ip_len)
               + 18'({vug_pkg::IP_TTL, vug_pkg::IP_PROTO_UDP})
               + 18'({vug_pkg::IP_SRC_NET, 8'h00})
               + 18'({vug_pkg::IP_MCAST, vug_pkg::IP_MCAST})
               + 18'(vlid_ff);
      csum_fold  = 17'(csum_sum[15:0]) + 17'(csum_sum[17:16]);
      csum_final = ~(csum_fold[15:0] + 16'(csum_fold[16]));
   end

   always_comb begin
      push_desc.vlid        = vlid_ff;
      push_desc.vlan_on     = vlan_on_ff;
      push_desc.tci         = {vlan_prio_ff, 1'b0, vlan_num_ff};
      push_desc.tail        = tail_ff;
      push_desc.head        = head_ff;
      push_desc.msg_len     = msg_len_ff;
      push_desc.payload_len = payload_len;
      push_desc.ip_csum     = csum_final;
      push_desc.frame_len   = frame_len;
      push_desc.word_count  = len_round[6:3];
      push_desc.ts          = req_timestamp_ns;
      push_desc.seq         = seq_ff;
   end

endmodule

// ===== rtl/vug_queue.sv =====
// descriptor queue between front and back end
// depends on vug_pkg
`timescale 1ns / 1ps
module vug_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vug_pkg::desc_type   push_desc,
   input  logic                pop,
   output vug_pkg::desc_type   head_desc,
   output vug_pkg::q_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vug_pkg::desc_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/vug_back.sv =====
// back end: streams one frame per descriptor, one beat per cycle unless the output stalls
// depends on vug_pkg
`timescale 1ns / 1ps
module vug_back (
   input  logic                clock,
   input  logic                reset,
   input  vug_pkg::desc_type   head_desc,
   input  vug_pkg::q_stat_type q_stat,
   output logic                pop,
   output logic [3:0]          word_idx,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [63:0]         rsp_frame_word,
   output logic [3:0]          rsp_valid_bytes,
   output logic                rsp_last_word
);

   localparam logic [6:0] MAC_END  = 7'd12;
   localparam logic [6:0] TAG_END  = MAC_END + 7'(vug_pkg::VLAN_TAG_BYTES);
   localparam logic [6:0] ETH_END  = 7'(vug_pkg::ETH_HDR_BYTES);
   localparam logic [6:0] IP_END   = ETH_END + 7'(vug_pkg::IP_HDR_BYTES);
   localparam logic [6:0] UDP_END  = IP_END + 7'(vug_pkg::UDP_HDR_BYTES);
   localparam logic [6:0] STAMP_N  = 7'(vug_pkg::STAMP_BYTES);
   localparam logic [6:0] TS_FIRST = 7'd3;
   localparam logic [6:0] TAIL_AT  = 7'(vug_pkg::REQ_HDR_BYTES);

   function automatic logic [7:0] frame_byte(input logic [6:0] pos,
                                             input vug_pkg::desc_type d);
      logic [6:0]  q;
      logic [6:0]  r;
      logic [6:0]  s;
      logic [6:0]  t;
      logic [15:0] ip_len;
      logic [15:0] udp_len;
      logic [7:0]  b;
      ip_len  = 16'(vug_pkg::IP_HDR_BYTES + vug_pkg::UDP_HDR_BYTES) + 16'(d.payload_len);
      udp_len = 16'(vug_pkg::UDP_HDR_BYTES) + 16'(d.payload_len);
      b = '0;
      q = pos;
      r = '0;
      s = '0;
      t = '0;
      if (pos < MAC_END) begin
         case (pos[3:0])
            4'd0:    b = vug_pkg::DST_MAC_FIRST;
            4'd4:    b = d.vlid[15:8];
            4'd5:    b = d.vlid[7:0];
            4'd6:    b = vug_pkg::SRC_MAC_FIRST;
            4'd11:   b = vug_pkg::SRC_MAC_LAST;
            default: b = '0;
         endcase
      end else if (d.vlan_on && pos < TAG_END) begin
         case (pos[1:0])
            2'd0:    b = vug_pkg::TPID_HI;
            2'd1:    b = '0;
            2'd2:    b = d.tci[15:8];
            default: b = d.tci[7:0];
         endcase
      end else begin
         // past the tag everything lines up with the untagged layout
         q = d.vlan_on ? pos - 7'(vug_pkg::VLAN_TAG_BYTES) : pos;
         if (q < ETH_END) begin
            b = (q == MAC_END) ? vug_pkg::ETYPE_IPV4_HI : 8'h00;
         end else if (q < IP_END) begin
            r = q - ETH_END;
            case (r[4:0])
               5'd0:    b = vug_pkg::IP_VER_IHL;
               5'd2:    b = ip_len[15:8];
               5'd3:    b = ip_len[7:0];
               5'd8:    b = vug_pkg::IP_TTL;
               5'd9:    b = vug_pkg::IP_PROTO_UDP;
               5'd10:   b = d.ip_csum[15:8];
               5'd11:   b = d.ip_csum[7:0];
               5'd12:   b = vug_pkg::IP_SRC_NET;
               5'd16:   b = vug_pkg::IP_MCAST;
               5'd17:   b = vug_pkg::IP_MCAST;
               5'd18:   b = d.vlid[15:8];
               5'd19:   b = d.vlid[7:0];
               default: b = '0;
            endcase
         end else if (q < UDP_END) begin
            r = q - IP_END;
            case (r[2:0])
               3'd1:    b = vug_pkg::UDP_PORT;
               3'd3:    b = vug_pkg::UDP_PORT;
               3'd4:    b = udp_len[15:8];
               3'd5:    b = udp_len[7:0];
               default: b = '0;
            endcase
         end else begin
            r = q - UDP_END;
            if (d.head && r < STAMP_N) begin
               b = 8'(d.seq >> {r[2:0], 3'b000});
            end else begin
               s = d.head ? r - STAMP_N : r;
               if (s == 7'd0) begin
                  b = vug_pkg::REQ_ID;
               end else if (s < TS_FIRST) begin
                  b = (s == 7'd1) ? d.msg_len[15:8] : d.msg_len[7:0];
               end else if (s < TAIL_AT) begin
                  t = s - TS_FIRST;
                  b = 8'(d.ts >> (6'd56 - {t[2:0], 3'b000}));
               end else if (d.tail == vug_pkg::TAIL_BYTE && s == TAIL_AT) begin
                  b = d.seq[7:0];
               end else if (d.tail == vug_pkg::TAIL_WORD && s < TAIL_AT + STAMP_N) begin
                  t = s - TAIL_AT;
                  b = 8'(d.seq >> {t[2:0], 3'b000});
               end
            end
         end
      end
      return b;
   endfunction

   logic [3:0]  word_ff, word_in;
   logic        valid_ff, valid_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  bytes_ff, bytes_in;
   logic        last_ff, last_in;
   logic        emit;
   logic        is_last;
   logic [6:0]  base;
   logic [6:0]  remain;

   assign emit     = !q_stat.empty && (!valid_ff || !rsp_stall);
   assign is_last  = (word_ff == head_desc.word_count - 4'd1);
   assign pop      = emit && is_last;
   assign word_idx = word_ff;
   assign base     = {word_ff, 3'b000};
   assign remain   = head_desc.frame_len - base;

   always_comb begin
      for (int i = 0; i < vug_pkg::BEAT_BYTES; i++) begin
         data_in[63 - 8 * i -: 8] = frame_byte(base + 7'(i), head_desc);
      end
      bytes_in = (remain > 7'(vug_pkg::BEAT_BYTES)) ? 4'(vug_pkg::BEAT_BYTES) : remain[3:0];
      last_in  = is_last;
      word_in  = word_ff;
      if (emit) begin
         word_in = is_last ? 4'd0 : word_ff + 4'd1;
      end
      valid_in = valid_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         word_ff  <= word_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff  <= data_in;
         bytes_ff <= bytes_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_word  = data_ff;
   assign rsp_valid_bytes = bytes_ff;
   assign rsp_last_word   = last_ff;

endmodule

// ===== rtl/vlan_ipv4_udp_frame_generator.sv =====
// frame generator top: optionally vlan-tagged ipv4/udp request frames in 64-bit beats
// a taken request is written into the descriptor queue, then its first beat into the output register
// each frame is 8 to 10 beats, one beat per cycle from the back end unless the output stalls;
// a queue of QUEUE_DEPTH descriptors lets the front take requests meanwhile
// reset: registers to defaults, sequence counter to zero, queue and output empty
// depends on vug_pkg, vug_front, vug_queue, vug_back and the assertion header
`timescale 1ns / 1ps
`include "vlan_ipv4_udp_frame_generator_assert.svh"
module vlan_ipv4_udp_frame_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_timestamp_ns,
   // result channel, one beat per frame word
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_frame_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_last_word,
   // register writes, always ready
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // front to queue
   logic                push_w;
   vug_pkg::desc_type   push_desc_w;
   // queue to back
   vug_pkg::desc_type   head_desc_w;
   vug_pkg::q_stat_type q_stat_w;
   logic                pop_w;
   logic [3:0]          word_idx_w;

   // front: latches config, stamps the sequence number, precomputes
   // lengths and the ip checksum so the back end only selects bytes
   vug_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_timestamp_ns (req_timestamp_ns),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_stat           (q_stat_w),
      .push             (push_w),
      .push_desc        (push_desc_w)
   );

   // short descriptor queue decouples request acceptance from streaming
   vug_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_w),
      .push_desc (push_desc_w),
      .pop       (pop_w),
      .head_desc (head_desc_w),
      .stat      (q_stat_w)
   );

   // back: walks the head descriptor word by word into the output register
   vug_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_desc       (head_desc_w),
      .q_stat          (q_stat_w),
      .pop             (pop_w),
      .word_idx        (word_idx_w),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_word  (rsp_frame_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_last_word   (rsp_last_word)
   );

   // front never pushes into a full queue
   `VUG_CHECK_NOW(a_no_overflow, push_w, !q_stat_w.full)
   // only the final beat of a frame may be partial
   `VUG_CHECK_NOW(a_full_beats, rsp_valid && !rsp_last_word, rsp_valid_bytes == 4'(vug_pkg::BEAT_BYTES))
   // word index stays inside the frame being streamed
   `VUG_CHECK_NOW(a_word_in_frame, !q_stat_w.empty, word_idx_w < head_desc_w.word_count)
   // after the last word of a frame the next frame starts at its first word
   `VUG_CHECK_NEXT(a_restart, pop_w, word_idx_w == 4'd0)

endmodule

// ===== tb/vlan_ipv4_udp_frame_generator_test.sv =====
// self-checking bench for the vlan/ipv4/udp frame generator: builds each frame
// in a scoreboard class and checks every output beat; depends on vug_pkg and the rtl
`timescale 1ns / 1ps
module vlan_ipv4_udp_frame_generator_test;
   import vug_pkg::*;

   // the register map has room for one index past the last register
   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;
   // fourth tail code carries no meaning and sends no tail stamp
   localparam logic [1:0] TAIL_UNUSED = 2'd3;
   localparam int IDLE_PERCENT = 25;
   localparam int RANDOM_PHASES = 5;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int REPORT_LIMIT = 10;

   // one output beat as the block should present it
   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } frame_beat_type;

   // one register setting of the whole block
   typedef struct {
      logic [15:0] vlid;
      logic        vlan_on;
      logic [11:0] vnum;
      logic [2:0]  prio;
      logic [1:0]  tail;
      logic        head;
      logic [15:0] mlen;
   } link_settings_type;

   typedef struct packed {
      logic [2:0]  idx;
      logic [15:0] data;
   } csr_write_type;

   // builds the expected frame per accepted request and checks beats in order
   class frame_beat_checker;
      logic [15:0] vlid = RST_VIRTUAL_LINK_ID;
      logic        vlan_on = RST_VLAN_TAGGED;
      logic [11:0] vnum = RST_VLAN_NUMBER;
      logic [2:0]  prio = RST_VLAN_PRIORITY;
      logic [1:0]  tail = RST_TAIL_STAMP_MODE;
      logic        head = RST_HEAD_STAMP_ENABLE;
      logic [15:0] mlen = RST_MESSAGE_LENGTH;
      logic [63:0] seq = '0;
      frame_beat_type expected_beats[$];
      int          beats_seen = 0;
      int          failures = 0;

      // register writes keep only the bits of the field
      function void write_register(logic [2:0] idx, logic [15:0] data);
         case (idx)
            REG_VIRTUAL_LINK_ID:   vlid = data;
            REG_VLAN_TAGGED:       vlan_on = data[0];
            REG_VLAN_NUMBER:       vnum = data[11:0];
            REG_VLAN_PRIORITY:     prio = data[2:0];
            REG_TAIL_STAMP_MODE:   tail = data[1:0];
            REG_HEAD_STAMP_ENABLE: head = data[0];
            REG_MESSAGE_LENGTH:    mlen = data;
            default: ;
         endcase
      endfunction

      function void add_frame(logic [63:0] ts);
         logic [7:0]  f [80];
         int          off, ipo, plen, len, nw, vb;
         logic [15:0] tot, udp, tci, cs;
         logic [31:0] sum;
         frame_beat_type b;
         foreach (f[i]) f[i] = 8'h00;
         // ethernet addresses
         f[0] = DST_MAC_FIRST;
         f[4] = vlid[15:8];
         f[5] = vlid[7:0];
         f[6] = SRC_MAC_FIRST;
         f[11] = SRC_MAC_LAST;
         off = 12;
         if (vlan_on) begin
            tci = {prio, 1'b0, vnum};
            f[off] = TPID_HI;
            f[off + 1] = 8'h00;
            f[off + 2] = tci[15:8];
            f[off + 3] = tci[7:0];
            off += 4;
         end
         f[off] = ETYPE_IPV4_HI;
         f[off + 1] = 8'h00;
         off += 2;
         plen = REQ_HDR_BYTES + (head ? STAMP_BYTES : 0);
         if (tail == TAIL_BYTE) plen += 1;
         else if (tail == TAIL_WORD) plen += STAMP_BYTES;
         tot = 16'(IP_HDR_BYTES + UDP_HDR_BYTES + plen);
         udp = 16'(UDP_HDR_BYTES + plen);
         // ipv4 header, checksum over all ten halfwords with the field zero
         ipo = off;
         f[ipo] = IP_VER_IHL;
         f[ipo + 2] = tot[15:8];
         f[ipo + 3] = tot[7:0];
         f[ipo + 8] = IP_TTL;
         f[ipo + 9] = IP_PROTO_UDP;
         f[ipo + 12] = IP_SRC_NET;
         f[ipo + 16] = IP_MCAST;
         f[ipo + 17] = IP_MCAST;
         f[ipo + 18] = vlid[15:8];
         f[ipo + 19] = vlid[7:0];
         sum = '0;
         for (int i = 0; i < IP_HDR_BYTES; i += 2) sum += 32'({f[ipo + i], f[ipo + i + 1]});
         while (sum[31:16] != 0) sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
         cs = ~sum[15:0];
         f[ipo + 10] = cs[15:8];
         f[ipo + 11] = cs[7:0];
         off = ipo + IP_HDR_BYTES;
         // udp header, checksum left zero
         f[off + 1] = UDP_PORT;
         f[off + 3] = UDP_PORT;
         f[off + 4] = udp[15:8];
         f[off + 5] = udp[7:0];
         off += UDP_HDR_BYTES;
         if (head) begin
            for (int i = 0; i < STAMP_BYTES; i++) f[off + i] = seq[8 * i +: 8];
            off += STAMP_BYTES;
         end
         f[off] = REQ_ID;
         f[off + 1] = mlen[15:8];
         f[off + 2] = mlen[7:0];
         off += 3;
         for (int i = 0; i < 8; i++) f[off + i] = ts[56 - 8 * i +: 8];
         off += 8;
         if (tail == TAIL_BYTE) begin
            f[off] = seq[7:0];
            off += 1;
         end else if (tail == TAIL_WORD) begin
            for (int i = 0; i < STAMP_BYTES; i++) f[off + i] = seq[8 * i +: 8];
            off += STAMP_BYTES;
         end
         len = (off < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : off;
         nw = (len + BEAT_BYTES - 1) / BEAT_BYTES;
         for (int w = 0; w < nw; w++) begin
            vb = (len - BEAT_BYTES * w > BEAT_BYTES) ? BEAT_BYTES : len - BEAT_BYTES * w;
            b.word = '0;
            for (int i = 0; i < vb; i++) b.word[63 - 8 * i -: 8] = f[BEAT_BYTES * w + i];
            b.nbytes = 4'(vb);
            b.last = (w == nw - 1);
            expected_beats.push_back(b);
         end
         seq += 64'd1;
      endfunction

      function void check_beat(logic [63:0] word, logic [3:0] nbytes, logic last);
         frame_beat_type e;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("beat %0d: no beat expected, got word %h bytes %0d last %b",
                        beats_seen, word, nbytes, last);
         end else begin
            e = expected_beats.pop_front();
            if (e.word !== word || e.nbytes !== nbytes || e.last !== last) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("beat %0d: expected word %h bytes %0d last %b, got %h %0d %b",
                           beats_seen, e.word, e.nbytes, e.last, word, nbytes, last);
            end
         end
      endfunction

      // beats still owed at the end count as one failure
      function void close_out();
         if (expected_beats.size() != 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0d beats never arrived", expected_beats.size());
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_timestamp_ns = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_frame_word;
   logic [3:0]  rsp_valid_bytes;
   logic        rsp_last_word;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // set during one random phase: neither side idles then
   logic steady = 1'b0;

   frame_beat_checker board = new();

   vlan_ipv4_udp_frame_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_timestamp_ns (req_timestamp_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_word   (rsp_frame_word),
      .rsp_valid_bytes  (rsp_valid_bytes),
      .rsp_last_word    (rsp_last_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #1_000_000;
      $display("vlan_ipv4_udp_frame_generator: mismatch");
      $finish;
   end

   // result side backpressure, one decision per edge
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
   end

   // a beat moves at an edge with valid high and our stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_beat(rsp_frame_word, rsp_valid_bytes, rsp_last_word);
   end

   function automatic logic [63:0] random_timestamp();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic link_settings_type random_settings();
      link_settings_type s;
      s.vlid = 16'($urandom);
      s.vlan_on = 1'($urandom_range(1));
      s.vnum = 12'($urandom);
      s.prio = 3'($urandom);
      s.tail = 2'($urandom_range(3));
      s.head = 1'($urandom_range(1));
      s.mlen = 16'($urandom);
      return s;
   endfunction

   // one request beat; the prediction is made at the accepting edge
   task automatic send_request(input logic [63:0] ts);
      while (!steady && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timestamp_ns <= ts;
      do @(posedge clock); while (req_stall);
      board.add_frame(ts);
   endtask

   // stop sending and let every owed beat come out
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register writes only once the block is idle; unused bits get noise
   task automatic apply_settings(input link_settings_type s);
      csr_write_type w [8];
      logic [15:0]   noise;
      drain();
      noise = 16'($urandom);
      w[0] = '{CSR_UNUSED_INDEX, noise};
      w[1] = '{REG_VIRTUAL_LINK_ID, s.vlid};
      w[2] = '{REG_VLAN_TAGGED, {noise[15:1], s.vlan_on}};
      w[3] = '{REG_VLAN_NUMBER, {noise[15:12], s.vnum}};
      w[4] = '{REG_VLAN_PRIORITY, {noise[15:3], s.prio}};
      w[5] = '{REG_TAIL_STAMP_MODE, {noise[15:2], s.tail}};
      w[6] = '{REG_HEAD_STAMP_ENABLE, {noise[15:1], s.head}};
      w[7] = '{REG_MESSAGE_LENGTH, s.mlen};
      foreach (w[i]) begin
         csr_valid <= 1'b1;
         csr_index <= w[i].idx;
         csr_data <= w[i].data;
         do @(posedge clock); while (!csr_ready);
         board.write_register(w[i].idx, w[i].data);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: tagged, one-byte tail stamp
      send_request('0);
      send_request('1);
      send_request(64'h0123_4567_89AB_CDEF);
      send_request(64'hAAAA_5555_AAAA_5555);

      // every field at its top, untagged, both stamps eight bytes
      apply_settings('{16'hFFFF, 1'b0, 12'hFFF, 3'd7, TAIL_WORD, 1'b1, 16'hFFFF});
      send_request('1);
      send_request(64'h8000_0000_0000_0001);
      send_request(random_timestamp());

      // every field at zero but the vlan flag, which stays tagged, meaningless tail code
      apply_settings('{16'h0000, 1'b1, 12'h000, 3'd0, TAIL_UNUSED, 1'b0, 16'h0000});
      send_request('0);
      send_request({$urandom, $urandom});

      // longest frame: tagged with both eight-byte stamps
      apply_settings('{16'h1234, 1'b1, 12'hFFF, 3'd7, TAIL_WORD, 1'b1, 16'h8000});
      send_request(64'h5555_AAAA_5555_AAAA);
      send_request(64'hFEDC_BA98_7654_3210);
      send_request({$urandom, $urandom});

      // shortest payload, padded out to the minimum frame
      apply_settings('{16'h00FF, 1'b0, 12'h001, 3'd3, TAIL_NONE, 1'b0, 16'h0001});
      send_request('0);
      send_request('1);
      send_request({$urandom, $urandom});

      // head stamp with a one-byte tail
      apply_settings('{16'h8001, 1'b1, 12'h800, 3'd4, TAIL_BYTE, 1'b1, 16'h7FFF});
      send_request({$urandom, $urandom});
      send_request({$urandom, $urandom});

      // random settings per phase; one phase runs with no idling on either side
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_settings(random_settings());
         steady <= (p == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_timestamp());
      end

      steady <= 1'b0;
      drain();
      repeat (20) @(posedge clock);
      board.close_out();
      if (board.failures == 0) begin
         $display("vlan_ipv4_udp_frame_generator: match");
      end else begin
         $display("vlan_ipv4_udp_frame_generator: mismatch");
      end
      $finish;
   end

endmodule
